[rtl/core/brc_pkg.sv]
package brc_pkg;

    // curve parameter and weight scales
    localparam logic [16:0] ONE_T = 17'h10000;
    localparam logic [32:0] ONE_W = 33'h1_0000_0000;
    localparam int unsigned NUM_PTS = 4;
    localparam int unsigned NUM_CRD = 2 * NUM_PTS;

    typedef logic [32:0] t_wt;

    // configuration register map
    typedef enum logic [1:0] {
        REG_M00 = 2'd0,
        REG_M01 = 2'd1,
        REG_M10 = 2'd2,
        REG_M11 = 2'd3
    } t_reg_idx;

    // clamp a 37-bit signed value to 32 bits
    function automatic logic [31:0] sat32(input logic [36:0] v);
        logic [31:0] r;
        if (!v[36] && (v[35:31] != 5'd0)) begin
            r = 32'h7FFF_FFFF;
        end else if (v[36] && (v[35:31] != 5'h1F)) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/brc_weights.sv]
module brc_weights
    import brc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic        i_is_cubic,
    input  logic [16:0] i_anchor_t,
    output t_wt         o_w [NUM_PTS]
);

    logic [16:0] t_sat;
    logic [16:0] u_val;
    logic [49:0] uuu;
    logic [49:0] tuu;
    logic [49:0] ttu;
    logic [51:0] tuu3;
    logic [51:0] ttu3;
    logic [32:0] w_last;

    logic [16:0] r_t;
    logic [16:0] r_u;
    logic [32:0] r_tu;
    logic [32:0] r_uu;
    logic        r_cub_a;
    t_wt         r_w0;
    t_wt         r_w1;
    t_wt         r_w2;
    logic        r_cub_b;
    t_wt         r_out [NUM_PTS];

    // stage a: clamp t, form u and the degree-two products
    assign t_sat = (i_anchor_t > ONE_T) ? ONE_T : i_anchor_t;
    assign u_val = ONE_T - t_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= t_sat;
            r_u     <= u_val;
            r_tu    <= 33'({17'd0, t_sat} * {17'd0, u_val});
            r_uu    <= 33'({17'd0, u_val} * {17'd0, u_val});
            r_cub_a <= i_is_cubic;
        end
    end

    // stage b: cubic products in q0.48, truncated to q0.32; quadratic weights otherwise
    assign uuu  = {17'd0, r_uu} * {33'd0, r_u};
    assign tuu  = {17'd0, r_tu} * {33'd0, r_u};
    assign ttu  = {17'd0, r_tu} * {33'd0, r_t};
    assign tuu3 = {2'd0, tuu} + {1'b0, tuu, 1'b0};
    assign ttu3 = {2'd0, ttu} + {1'b0, ttu, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cub_b <= r_cub_a;
            if (r_cub_a) begin
                r_w0 <= uuu[48:16];
                r_w1 <= tuu3[48:16];
                r_w2 <= ttu3[48:16];
            end else begin
                r_w0 <= r_uu;
                r_w1 <= {r_tu[31:0], 1'b0};
                r_w2 <= '0;
            end
        end
    end

    // stage c: last weight makes the sum exactly one
    assign w_last = ONE_W - r_w0 - r_w1 - r_w2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out[0] <= r_w0;
            r_out[1] <= r_w1;
            r_out[2] <= r_cub_b ? r_w2 : w_last;
            r_out[3] <= r_cub_b ? w_last : '0;
        end
    end

    assign o_w = r_out;

endmodule

[rtl/core/bezier_rotate_about_curve_point.sv]
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_stall  | i_is_cubic, i_anchor_t, i_p0_x .. i_p3_y
// output  | out       | o_valid / i_stall  | o_center_x, o_center_y, o_q0_x .. o_q3_y
// config  | in        | apb psel / penable | paddr, pwdata, prdata
//
// nine register stages: three for the bernstein weights, three for the
// weighted sum and rounding of the center, three for difference, matrix
// product and final rounding; one request per cycle while no result is held.
// reset is synchronous, clears the valid bits and sets the matrix registers to identity.
// a stalled result freezes the whole pipeline in place; nothing is dropped.
module bezier_rotate_about_curve_point
    import brc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_is_cubic,
    input  logic [16:0] i_anchor_t,
    input  logic [31:0] i_p0_x,
    input  logic [31:0] i_p0_y,
    input  logic [31:0] i_p1_x,
    input  logic [31:0] i_p1_y,
    input  logic [31:0] i_p2_x,
    input  logic [31:0] i_p2_y,
    input  logic [31:0] i_p3_x,
    input  logic [31:0] i_p3_y,
    // result out
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_center_x,
    output logic [31:0] o_center_y,
    output logic [31:0] o_q0_x,
    output logic [31:0] o_q0_y,
    output logic [31:0] o_q1_x,
    output logic [31:0] o_q1_y,
    output logic [31:0] o_q2_x,
    output logic [31:0] o_q2_y,
    output logic [31:0] o_q3_x,
    output logic [31:0] o_q3_y
);

    localparam int unsigned NStg = 9;
    localparam int unsigned NDly = 6;

    logic        en;
    logic        acc_in;
    t_reg_idx    reg_idx;
    logic [31:0] pts_in [NUM_CRD];
    t_wt         w [NUM_PTS];
    logic [15:0] mrow [2][2];

    logic [15:0] r_m00;
    logic [15:0] r_m01;
    logic [15:0] r_m10;
    logic [15:0] r_m11;
    logic [NStg-1:0] r_vld;
    logic [NStg-1:0] r_cub;
    logic [31:0] r_pts [NDly][NUM_CRD];
    logic [65:0] r_prod [NUM_CRD];
    logic [66:0] r_half [2][2];
    logic [31:0] r_ctr_f [2];
    logic [31:0] r_ctr_g [2];
    logic [31:0] r_ctr_h [2];
    logic [32:0] r_dif [NUM_CRD];
    logic [48:0] r_mp [NUM_CRD][2];
    logic [31:0] r_q [NUM_CRD];
    logic [31:0] r_ctr_o [2];

    // config registers
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m00 <= 16'h4000;
            r_m01 <= 16'h0000;
            r_m10 <= 16'h0000;
            r_m11 <= 16'h4000;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_M00: r_m00 <= pwdata[15:0];
                REG_M01: r_m01 <= pwdata[15:0];
                REG_M10: r_m10 <= pwdata[15:0];
                REG_M11: r_m11 <= pwdata[15:0];
                default: r_m00 <= r_m00;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_M00: prdata = {16'd0, r_m00};
            REG_M01: prdata = {16'd0, r_m01};
            REG_M10: prdata = {16'd0, r_m10};
            REG_M11: prdata = {16'd0, r_m11};
            default: prdata = '0;
        endcase
    end

    assign mrow[0][0] = r_m00;
    assign mrow[0][1] = r_m01;
    assign mrow[1][0] = r_m10;
    assign mrow[1][1] = r_m11;

    // pipeline advance: hold everything while the result is stalled
    assign en      = !(r_vld[NStg-1] && i_stall);
    assign o_stall = !en;
    assign acc_in  = i_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NStg-2:0], acc_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cub <= {r_cub[NStg-2:0], i_is_cubic};
        end
    end

    // weights
    brc_weights u_weights (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_is_cubic (i_is_cubic),
        .i_anchor_t (i_anchor_t),
        .o_w        (w)
    );

    // control point delay line
    assign pts_in[0] = i_p0_x;
    assign pts_in[1] = i_p0_y;
    assign pts_in[2] = i_p1_x;
    assign pts_in[3] = i_p1_y;
    assign pts_in[4] = i_p2_x;
    assign pts_in[5] = i_p2_y;
    assign pts_in[6] = i_p3_x;
    assign pts_in[7] = i_p3_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pts[0] <= pts_in;
            for (int s = 1; s < NDly; s++) begin
                r_pts[s] <= r_pts[s-1];
            end
        end
    end

    // stage d: point times weight
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NUM_CRD; k++) begin
                r_prod[k] <= {{34{r_pts[2][k][31]}}, r_pts[2][k]} * {33'd0, w[k/2]};
            end
        end
    end

    // stage e: pairwise sums per axis
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 2; a++) begin
                for (int h = 0; h < 2; h++) begin
                    r_half[a][h] <= {r_prod[4*h+a][65], r_prod[4*h+a]}
                                  + {r_prod[4*h+2+a][65], r_prod[4*h+2+a]};
                end
            end
        end
    end

    // stage f: total, round half up to q16.16, saturate
    always_ff @(posedge i_clk) begin
        logic [67:0] tot;
        if (en) begin
            for (int a = 0; a < 2; a++) begin
                tot = {r_half[a][0][66], r_half[a][0]} + {r_half[a][1][66], r_half[a][1]}
                    + 68'h0_8000_0000;
                r_ctr_f[a] <= sat32({tot[67], tot[67:32]});
            end
        end
    end

    // stage g: offset from center
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctr_g <= r_ctr_f;
            for (int k = 0; k < NUM_CRD; k++) begin
                r_dif[k] <= {r_pts[5][k][31], r_pts[5][k]}
                          - {r_ctr_f[k%2][31], r_ctr_f[k%2]};
            end
        end
    end

    // stage h: matrix products, one per term
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctr_h <= r_ctr_g;
            for (int k = 0; k < NUM_CRD; k++) begin
                for (int j = 0; j < 2; j++) begin
                    r_mp[k][j] <= {{33{mrow[k%2][j][15]}}, mrow[k%2][j]}
                                * {{16{r_dif[(k/2)*2+j][32]}}, r_dif[(k/2)*2+j]};
                end
            end
        end
    end

    // stage i: sum terms, round, add center back, saturate; last point is zero if quadratic
    always_ff @(posedge i_clk) begin
        logic [49:0] acc;
        logic [36:0] res;
        if (en) begin
            r_ctr_o <= r_ctr_h;
            for (int k = 0; k < NUM_CRD; k++) begin
                acc = {r_mp[k][0][48], r_mp[k][0]} + {r_mp[k][1][48], r_mp[k][1]}
                    + 50'd8192;
                res = {acc[49], acc[49:14]} + {{5{r_ctr_h[k%2][31]}}, r_ctr_h[k%2]};
                if ((k >= NUM_CRD - 2) && !r_cub[NStg-2]) begin
                    r_q[k] <= '0;
                end else begin
                    r_q[k] <= sat32(res);
                end
            end
        end
    end

    assign o_valid    = r_vld[NStg-1];
    assign o_center_x = r_ctr_o[0];
    assign o_center_y = r_ctr_o[1];
    assign o_q0_x     = r_q[0];
    assign o_q0_y     = r_q[1];
    assign o_q1_x     = r_q[2];
    assign o_q1_y     = r_q[3];
    assign o_q2_x     = r_q[4];
    assign o_q2_y     = r_q[5];
    assign o_q3_x     = r_q[6];
    assign o_q3_y     = r_q[7];

endmodule

[rtl/core/brc_checker.sv]
module brc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        pready,
    input logic [31:0] o_center_x,
    input logic [31:0] o_q0_x
);

    // input side only backs up when a finished result is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_center_x) && $stable(o_q0_x)))
        else $error("held result changed");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // config port never waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port not ready");

endmodule

bind bezier_rotate_about_curve_point brc_checker u_brc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .pready     (pready),
    .o_center_x (o_center_x),
    .o_q0_x     (o_q0_x)
);

[verif/bezier_rotate_about_curve_point_chk.sv]
`timescale 1ns / 100ps

module bezier_rotate_about_curve_point_chk
    import brc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        i_is_cubic,
    input  logic [16:0] i_anchor_t,
    input  logic [31:0] i_px [NUM_PTS],
    input  logic [31:0] i_py [NUM_PTS],
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_cx,
    input  logic [31:0] o_cy,
    input  logic [31:0] o_qx [NUM_PTS],
    input  logic [31:0] o_qy [NUM_PTS],
    output int          o_fail_cnt,
    output int          o_pending,
    output logic        o_activity
);

    typedef struct {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] qx [NUM_PTS];
        logic [31:0] qy [NUM_PTS];
    } t_curve_res;

    logic signed [15:0] mat [4];
    t_curve_res         rotated_q [$];

    // saturate to signed 32 bits
    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // apply one row of the matrix to a difference vector, plus the center
    function automatic logic signed [31:0] rotate_axis(input longint ma, input longint mb,
            input longint dx, input longint dy, input longint c);
        longint acc;
        acc = ma * dx + mb * dy + 8192;
        return clamp32((acc >>> 14) + c);
    endfunction

    // center and rotated points for one request
    function automatic t_curve_res rotate_curve(input logic cubic, input logic [16:0] tin,
            input logic [31:0] px [NUM_PTS], input logic [31:0] py [NUM_PTS]);
        t_curve_res    r;
        longint unsigned t, u;
        longint unsigned w [NUM_PTS];
        longint        sx, sy, cx, cy, dx, dy;
        int            n;
        t = (tin > ONE_T) ? 64'd65536 : 64'(tin);
        u = 65536 - t;
        if (cubic) begin
            n = 4;
            w[0] = (u * u * u) >> 16;
            w[1] = (3 * t * u * u) >> 16;
            w[2] = (3 * t * t * u) >> 16;
            w[3] = 64'h1_0000_0000 - w[0] - w[1] - w[2];
        end else begin
            n = 3;
            w[0] = u * u;
            w[1] = 2 * t * u;
            w[2] = 64'h1_0000_0000 - w[0] - w[1];
            w[3] = 0;
        end
        sx = 0;
        sy = 0;
        for (int i = 0; i < n; i++) begin
            sx += longint'($signed(px[i])) * longint'(w[i]);
            sy += longint'($signed(py[i])) * longint'(w[i]);
        end
        cx = clamp32((sx + 64'sd2147483648) >>> 32);
        cy = clamp32((sy + 64'sd2147483648) >>> 32);
        r.cx = cx[31:0];
        r.cy = cy[31:0];
        for (int i = 0; i < NUM_PTS; i++) begin
            if (i < n) begin
                dx = longint'($signed(px[i])) - cx;
                dy = longint'($signed(py[i])) - cy;
                r.qx[i] = rotate_axis(mat[REG_M00], mat[REG_M01], dx, dy, cx);
                r.qy[i] = rotate_axis(mat[REG_M10], mat[REG_M11], dx, dy, cy);
            end else begin
                r.qx[i] = '0;
                r.qy[i] = '0;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
            input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            o_fail_cnt++;
        end
    endtask

    assign o_pending = rotated_q.size();

    always @(posedge i_clk) begin
        t_curve_res e;
        logic       act;
        act = 1'b0;
        if (!i_rst_n) begin
            o_fail_cnt = 0;
            mat[REG_M00] <= 16'sd16384;
            mat[REG_M01] <= 16'sd0;
            mat[REG_M10] <= 16'sd0;
            mat[REG_M11] <= 16'sd16384;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                mat[paddr[3:2]] <= pwdata[15:0];
                act = 1'b1;
            end
            // accepted request
            if (i_valid && !o_stall) begin
                rotated_q.push_back(rotate_curve(i_is_cubic, i_anchor_t, i_px, i_py));
                act = 1'b1;
            end
            // accepted result
            if (o_valid && !i_stall) begin
                act = 1'b1;
                if (rotated_q.size() == 0) begin
                    $error("result with no request pending");
                    o_fail_cnt++;
                end else begin
                    e = rotated_q.pop_front();
                    check_field("center_x", e.cx, o_cx);
                    check_field("center_y", e.cy, o_cy);
                    for (int i = 0; i < NUM_PTS; i++) begin
                        check_field($sformatf("q%0d_x", i), e.qx[i], o_qx[i]);
                        check_field($sformatf("q%0d_y", i), e.qy[i], o_qy[i]);
                    end
                end
            end
        end
        o_activity <= act;
    end

endmodule

[verif/bezier_rotate_about_curve_point_tb.sv]
`timescale 1ns / 100ps

module bezier_rotate_about_curve_point_tb;
    import brc_pkg::*;

    localparam int NUM_RAND  = 1800;
    localparam int WDOG_MAX  = 2000;
    localparam int LATENCY   = 9;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        i_valid, o_stall, i_is_cubic, o_valid, i_stall;
    logic [16:0] i_anchor_t;
    logic [31:0] i_px [NUM_PTS];
    logic [31:0] i_py [NUM_PTS];
    logic [31:0] o_cx, o_cy;
    logic [31:0] o_qx [NUM_PTS];
    logic [31:0] o_qy [NUM_PTS];
    int          fail_cnt, pending;
    logic        activity;
    int          idle_cnt;
    bit          quiet;

    bezier_rotate_about_curve_point u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_is_cubic(i_is_cubic),
        .i_anchor_t(i_anchor_t),
        .i_p0_x(i_px[0]), .i_p0_y(i_py[0]), .i_p1_x(i_px[1]), .i_p1_y(i_py[1]),
        .i_p2_x(i_px[2]), .i_p2_y(i_py[2]), .i_p3_x(i_px[3]), .i_p3_y(i_py[3]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_center_x(o_cx), .o_center_y(o_cy),
        .o_q0_x(o_qx[0]), .o_q0_y(o_qy[0]), .o_q1_x(o_qx[1]), .o_q1_y(o_qy[1]),
        .o_q2_x(o_qx[2]), .o_q2_y(o_qy[2]), .o_q3_x(o_qx[3]), .o_q3_y(o_qy[3])
    );

    bezier_rotate_about_curve_point_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_is_cubic(i_is_cubic),
        .i_anchor_t(i_anchor_t), .i_px(i_px), .i_py(i_py),
        .o_valid(o_valid), .i_stall(i_stall), .o_cx(o_cx), .o_cy(o_cy),
        .o_qx(o_qx), .o_qy(o_qy),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_activity(activity)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if (activity || !i_rst_n) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= WDOG_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result-side stall bursts
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 11);
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic set_matrix(input logic [15:0] a, input logic [15:0] b,
            input logic [15:0] c, input logic [15:0] d);
        drain();
        write_reg(REG_M00, a);
        write_reg(REG_M01, b);
        write_reg(REG_M10, c);
        write_reg(REG_M11, d);
    endtask

    // one request, with optional sender gap first
    task automatic send_curve(input logic cubic, input logic [16:0] t,
            input logic [31:0] v [2*NUM_PTS]);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_is_cubic <= cubic;
        i_anchor_t <= t;
        for (int i = 0; i < NUM_PTS; i++) begin
            i_px[i] <= v[2*i];
            i_py[i] <= v[2*i+1];
        end
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 65535 * 8) - 32'd262144;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [16:0] rand_t();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return ONE_T;
            2: return 17'(32'h10000 + $urandom_range(1, 65535));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic rand_block(input int cnt);
        logic [31:0] v [2*NUM_PTS];
        for (int k = 0; k < cnt; k++) begin
            for (int j = 0; j < 2*NUM_PTS; j++) v[j] = rand_coord();
            send_curve(1'($urandom_range(0, 1)), rand_t(), v);
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] v [2*NUM_PTS];
        quiet      = 1'b0;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_valid    = 1'b0;
        i_is_cubic = 1'b0;
        i_anchor_t = '0;
        for (int i = 0; i < NUM_PTS; i++) begin
            i_px[i] = '0;
            i_py[i] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes of t, degrees, coordinates, anchor beyond one
        for (int k = 0; k < 16; k++) begin
            for (int j = 0; j < 2*NUM_PTS; j++) begin
                case (k % 4)
                    0: v[j] = 32'h7FFF_FFFF;
                    1: v[j] = 32'h8000_0000;
                    2: v[j] = (j % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    default: v[j] = 32'h0001_0000 * j;
                endcase
            end
            send_curve(k[0] ^ k[2], (k < 4) ? 17'd0 : (k < 8) ? ONE_T :
                (k < 12) ? 17'h1FFFF : 17'h08000, v);
        end
        i_valid <= 1'b0;

        // identity at reset, then several matrices, extremes included
        rand_block(200);
        set_matrix(16'sd0, -16'sd16384, 16'sd16384, 16'sd0);
        rand_block(250);
        set_matrix(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        rand_block(250);
        set_matrix(16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF);
        rand_block(250);
        set_matrix(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        rand_block(250);
        set_matrix(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        rand_block(200);
        drain();
        set_matrix(16'sd11585, -16'sd11585, 16'sd11585, 16'sd11585);
        rand_block(200);

        // last part with no idling
        quiet = 1'b1;
        rand_block(200);

        drain();
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/brc_pkg.sv
rtl/core/brc_weights.sv
rtl/core/bezier_rotate_about_curve_point.sv
rtl/core/brc_checker.sv
verif/bezier_rotate_about_curve_point_chk.sv
verif/bezier_rotate_about_curve_point_tb.sv
